/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/biqe_pkg.sv */
// package for the quadtree encoder: widths, opcodes, word types
// no dependencies
package biqe_pkg;
    localparam int MAX_SIDE_LOG2 = 6;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [5:0] pixel_row;
        logic [5:0] pixel_col;
        logic       pixel_bit;
    } in_word_t;

    typedef struct packed {
        logic       node_is_leaf;
        logic       node_value;
        logic [2:0] node_level;
        logic [5:0] node_row;
        logic [5:0] node_col;
        logic       last_node;
    } out_word_t;
endpackage

/* hdl/biqe_if.sv */
// valid/ready channel interface carrying one word
// no dependencies; biqe_pkg types come in through the type parameter
interface biqe_if #(parameter type word_t = logic) (input logic clk);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/biqe_engine.sv */
// pixel and pyramid memories with pyramid build and preorder walk
// depends on biqe_pkg
module biqe_engine #(
    parameter int MAX_SIDE_LOG2 = biqe_pkg::MAX_SIDE_LOG2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          side_cfg,
    input  logic                cfg_we,
    input  logic                in_valid,
    output logic                in_ready,
    input  biqe_pkg::in_word_t  in_word,
    output logic                res_valid,
    input  logic                res_ready,
    output biqe_pkg::out_word_t res_word
);
    localparam int AW = 2 * MAX_SIDE_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam int LW = $clog2(MAX_SIDE_LOG2 + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BUILD = 6'b000010,
        S_BWAIT = 6'b000100,
        S_NREAD = 6'b001000,
        S_NWAIT = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // pixel memory in morton order, mixed flags per node by (level, z)
    logic pix_mem [DEPTH];
    logic mix_mem [DEPTH];
    logic pix_q, mix_q;
    logic [AW-1:0] pix_ra, mix_ra, mix_wa;
    logic mix_we, mix_wd;

    logic active_reg;
    logic [LW-1:0] lvl_reg, k_sel;
    logic [AW-1:0] z_reg;
    logic [AW-1:0] bz_reg;
    logic [LW-1:0] bl_reg;
    logic [1:0] bc_reg;
    logic bfirst_reg, bm_reg;
    logic res_valid_reg;
    biqe_pkg::out_word_t res_reg;

    assign k_sel = (side_cfg > 3'(MAX_SIDE_LOG2)) ? LW'(MAX_SIDE_LOG2) : LW'(side_cfg);

    // interleave row and column into a morton address
    function automatic logic [AW-1:0] morton(input logic [5:0] r, input logic [5:0] c);
        logic [AW-1:0] z;
        z = '0;
        for (int b = 0; b < MAX_SIDE_LOG2 && b < 6; b++)
        begin
            z[2*b] = c[b];
            z[2*b+1] = r[b];
        end
        return z;
    endfunction

    // build: for level bl, child c of node bz (node base, level bl step)
    logic [AW-1:0] child_z;
    assign child_z = bz_reg[AW-1:0] | (AW'(bc_reg) << (2 * (bl_reg - 1)));
    logic [AW-1:0] total_m1;
    assign total_m1 = AW'((1 << (2 * k_sel)) - 1);

    always_comb
    begin
        pix_ra = (state_reg == S_BUILD || state_reg == S_BWAIT) ? child_z : z_reg;
        mix_ra = pix_ra;
    end
    // mixed flag for (level, z) stored at z with level folded: use per-level key
    // key: low 2*level bits of z are zero, so set bit level-1 pattern as marker
    function automatic logic [AW-1:0] mkey(input logic [LW-1:0] l, input logic [AW-1:0] z);
        logic [AW-1:0] m;
        m = (AW'(1) << (2 * l)) - AW'(1);
        return (z & ~m) | (m >> 1) ;
    endfunction
    logic [AW-1:0] mix_rkey;

    // memory read/write ports
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_word.opcode == biqe_pkg::OP_WRITE &&
            (MAX_SIDE_LOG2 >= 6 || ((in_word.pixel_row >> MAX_SIDE_LOG2) == 0 &&
                                    (in_word.pixel_col >> MAX_SIDE_LOG2) == 0)))
            pix_mem[morton(in_word.pixel_row, in_word.pixel_col)] <= in_word.pixel_bit;
        if (mix_we)
            mix_mem[mix_wa] <= mix_wd;
        pix_q <= pix_mem[pix_ra];
        mix_q <= mix_mem[mix_rkey];
    end

    logic [LW-1:0] rlvl;
    always_comb
    begin
        rlvl = (state_reg == S_BUILD || state_reg == S_BWAIT) ? LW'(bl_reg - 1) : lvl_reg;
        mix_rkey = mkey(rlvl, mix_ra);
    end

    // build step: one child per S_BUILD/S_BWAIT pair, read then compare
    always_comb
    begin
        mix_we = 1'b0;
        mix_wa = mkey(bl_reg, bz_reg[AW-1:0]);
        mix_wd = bm_reg | (bc_reg != 2'd0 && pix_q != bfirst_reg) || (bl_reg > 1 && mix_q);
        if (state_reg == S_BWAIT && bc_reg == 2'd3)
            mix_we = 1'b1;
    end

    assign in_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_word = res_reg;

    logic node_mixed;
    assign node_mixed = (lvl_reg != '0) && mix_q;
    logic [AW:0] nz;
    logic [LW-1:0] nl;
    always_comb
    begin
        nz = {1'b0, z_reg} + ((AW+1)'(1) << (2 * lvl_reg));
        nl = lvl_reg;
        for (int i = 0; i < MAX_SIDE_LOG2; i++)
            if (nl < k_sel && ((nz >> (2 * nl)) & 3) == 0)
                nl = nl + 1'b1;
    end
    logic [5:0] rr, cc;
    always_comb
    begin
        rr = '0;
        cc = '0;
        for (int b = 0; b < MAX_SIDE_LOG2 && b < 6; b++)
        begin
            rr[b] = z_reg[2*b+1];
            cc[b] = z_reg[2*b];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready && in_word.opcode == biqe_pkg::OP_REQUEST)
                    state_next = (active_reg || k_sel == '0) ? S_NREAD : S_BUILD;
            S_BUILD: state_next = S_BWAIT;
            S_BWAIT:
                if (bc_reg == 2'd3 && bl_reg == k_sel &&
                    bz_reg[AW-1:0] == (total_m1 & ~((AW'(1) << (2 * bl_reg)) - AW'(1))))
                    state_next = S_NREAD;
                else
                    state_next = S_BUILD;
            S_NREAD: state_next = S_NWAIT;
            S_NWAIT: state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            active_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            lvl_reg <= LW'(MAX_SIDE_LOG2);
            z_reg <= '0;
            bl_reg <= LW'(1);
            bz_reg <= '0;
            bc_reg <= '0;
            bfirst_reg <= 1'b0;
            bm_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            if (cfg_we)
                active_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        if (in_word.opcode == biqe_pkg::OP_WRITE)
                            active_reg <= 1'b0;
                        else if (!active_reg)
                        begin
                            lvl_reg <= k_sel;
                            z_reg <= '0;
                            bl_reg <= LW'(1);
                            bz_reg <= '0;
                            bc_reg <= '0;
                            active_reg <= 1'b1;
                        end
                    end
                S_BWAIT:
                begin
                    if (bc_reg == 2'd0)
                        bfirst_reg <= pix_q;
                    bm_reg <= (bc_reg == 2'd0) ? (bl_reg > 1 && mix_q) : mix_wd;
                    bc_reg <= bc_reg + 2'd1;
                    if (bc_reg == 2'd3)
                    begin
                        if ((bz_reg[AW-1:0] | ((AW'(1) << (2 * bl_reg)) - AW'(1))) == total_m1)
                        begin
                            bz_reg <= '0;
                            bl_reg <= bl_reg + 1'b1;
                        end
                        else
                            bz_reg <= bz_reg + (AW'(1) << (2 * bl_reg));
                    end
                end
                S_NWAIT:
                begin
                    res_reg.node_is_leaf <= !node_mixed;
                    res_reg.node_value <= pix_q;
                    res_reg.node_level <= 3'(lvl_reg);
                    res_reg.node_row <= rr;
                    res_reg.node_col <= cc;
                    res_reg.last_node <= 1'b0;
                    if (node_mixed)
                        lvl_reg <= lvl_reg - 1'b1;
                    else if (nz > {1'b0, total_m1})
                    begin
                        res_reg.last_node <= 1'b1;
                        active_reg <= 1'b0;
                        lvl_reg <= k_sel;
                        z_reg <= '0;
                    end
                    else
                    begin
                        lvl_reg <= nl;
                        z_reg <= nz[AW-1:0];
                    end
                end
                S_OUT: res_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

/* hdl/binary_image_quadtree_encoder_unit.sv */
// top level of the quadtree encoder: config register and channel wiring
// depends on biqe_pkg, biqe_if, biqe_engine and assert_macros.svh
// A write word stores one pixel when accepted. The first request after any
// write, config write or last node builds (for a nonzero side) a mixed-flag
// pyramid over the image, reading one child at a time through the single
// pixel memory port. Every request then returns one node: a memory read of
// pixel and flag, the cursor update and the output register.
`include "assert_macros.svh"
module binary_image_quadtree_encoder_unit #(
    parameter int MAX_SIDE_LOG2 = biqe_pkg::MAX_SIDE_LOG2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    biqe_if.sink       in_ch,
    biqe_if.source     out_ch
);
    logic [2:0] side_reg;

    // side register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= 3'd6;
        else if (cfg_we)
            side_reg <= cfg_wdata;
    end

    biqe_engine #(.MAX_SIDE_LOG2(MAX_SIDE_LOG2)) u_engine (
        .clk(clk), .rst_n(rst_n), .side_cfg(side_reg), .cfg_we(cfg_we),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_word(in_ch.data),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_word(out_ch.data)
    );

    `ASSERT_IMPL(a_no_accept_while_out, clk, rst_n, out_ch.valid, !in_ch.ready)
    `ASSERT_NEXT(a_write_no_result, clk, rst_n,
        in_ch.valid && in_ch.ready && in_ch.data.opcode == biqe_pkg::OP_WRITE,
        !out_ch.valid)
endmodule
